FILE: sv/psma_pkg.sv
// shared types, constants and lookup tables for the p1 stiffness matrix assembly block
// no dependencies; imported by every module of the block
package psma_pkg;

  localparam int FRAC    = 16;
  localparam int IDX_W   = 8;
  localparam int NODES   = 256;
  localparam int CNT_W   = 9;
  localparam int COORD_W = 24;
  localparam int ENTRY_W = 48;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int SUM_W   = COORD_W + 2;
  localparam int NUM_W   = SUM_W + FRAC + 1;
  localparam int DEN_W   = COORD_W + 4;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int CHUNK_W = 17;
  localparam int PP_W    = NUM_W + CHUNK_W;
  localparam int ACC_W   = NUM_W + DOT_W;
  localparam int DIVC_W  = 6;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ELEM = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_INDEX = 2'd1;
  localparam logic [1:0] STAT_AREA  = 2'd2;

  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

  // upper-triangle pairs of edge dot products
  localparam logic [1:0] PAIR_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_J [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  // local entry order: row-major over a, b, c
  localparam logic [1:0] ROW_OF  [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] COL_OF  [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [2:0] PAIR_OF [9] = '{3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5};

  typedef struct packed {
    logic        [COORD_W-1:0] coef;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } node_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [IDX_W-1:0] addr;
    node_t            wdata;
  } node_req_t;

  typedef struct packed {
    logic                      re;
    logic                      we;
    logic [ADDR_W-1:0]         addr;
    logic signed [ENTRY_W-1:0] wdata;
  } mat_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NREAD,
    ST_PREP,
    ST_DIV,
    ST_KCALC,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_MCLR,
    ST_DONE
  } state_e;

endpackage

FILE: sv/psma_node_mem.sv
// node table memory: x, y and coefficient of each node in one word
// depends on psma_pkg
module psma_node_mem
  import psma_pkg::*;
(
  input  logic      clk_i,
  input  node_req_t req_i,
  output node_t     rdata_o
);

  node_t mem [NODES];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/psma_mat_mem.sv
// stiffness matrix memory, single port, with a clearing sweep after reset
// depends on psma_pkg
module psma_mat_mem
  import psma_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mat_req_t                  req_i,
  output logic signed [ENTRY_W-1:0] rdata_o,
  output logic                      ready_o
);

  logic signed [ENTRY_W-1:0] mem [NODES*NODES];
  logic signed [ENTRY_W-1:0] rdata_q;
  logic                      clr_busy_q;
  logic [ADDR_W-1:0]         clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (&clr_addr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

FILE: sv/psma_div.sv
// restoring divider, one quotient bit per cycle
// depends on psma_pkg
module psma_div
  import psma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIVC_W-1:0] cnt_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  quot_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIVC_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIVC_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      quot_q <= {quot_q[NUM_W-2:0], ge};
      rem_q  <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: sv/psma_kcalc.sv
// local stiffness entries: edge dot products and scaling by the factor
// depends on psma_pkg; one shared multiplier for dots, one for partial products
module psma_kcalc
  import psma_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          f_i,
  input  node_t [2:0]               nodes_i,
  output logic                      done_o,
  output logic signed [ENTRY_W-1:0] k_o [6]
);

  logic signed [EDGE_W-1:0]  ex_q [3];
  logic signed [EDGE_W-1:0]  ey_q [3];
  logic [NUM_W-1:0]          f_q;
  logic                      busy_q;
  logic                      done_q;
  logic [2:0]                pair_q;
  logic [3:0]                ph_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [DOT_W-1:0]   dot_q;
  logic [DOT_W-1:0]          mag_q;
  logic                      neg_q;
  logic [PP_W-1:0]           pp_q;
  logic [ACC_W-1:0]          acc_q;
  logic signed [ENTRY_W-1:0] k_q [6];

  logic [1:0]                ia, ja;
  logic [CHUNK_W-1:0]        chunk;
  logic [PP_W-1:0]           pp_w;
  logic [ACC_W:0]            rnd;
  logic                      sat;
  logic [ENTRY_W-2:0]        qv;
  logic signed [ENTRY_W-1:0] k_w;

  assign ia = PAIR_I[pair_q];
  assign ja = PAIR_J[pair_q];

  always_comb begin
    unique case (ph_q)
      4'd4:    chunk = mag_q[CHUNK_W-1:0];
      4'd5:    chunk = mag_q[2*CHUNK_W-1:CHUNK_W];
      default: chunk = mag_q[3*CHUNK_W-1:2*CHUNK_W];
    endcase
  end

  assign pp_w = f_q * chunk;
  assign rnd  = {1'b0, acc_q} + ((ACC_W+1)'(1) << (2*FRAC - 1));
  assign sat  = |rnd[ACC_W:2*FRAC+ENTRY_W-1];
  assign qv   = rnd[2*FRAC+ENTRY_W-2:2*FRAC];

  always_comb begin
    if (neg_q) begin
      k_w = sat ? ENTRY_MIN : -$signed({1'b0, qv});
    end else begin
      k_w = sat ? ENTRY_MAX : $signed({1'b0, qv});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pair_q <= '0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        pair_q <= '0;
        ph_q   <= '0;
      end else if (busy_q) begin
        if (ph_q == 4'd8) begin
          ph_q <= '0;
          if (pair_q == 3'd5) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            pair_q <= pair_q + 3'd1;
          end
        end else begin
          ph_q <= ph_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      f_q      <= f_i;
      ex_q[0]  <= EDGE_W'(nodes_i[2].x) - EDGE_W'(nodes_i[1].x);
      ey_q[0]  <= EDGE_W'(nodes_i[2].y) - EDGE_W'(nodes_i[1].y);
      ex_q[1]  <= EDGE_W'(nodes_i[0].x) - EDGE_W'(nodes_i[2].x);
      ey_q[1]  <= EDGE_W'(nodes_i[0].y) - EDGE_W'(nodes_i[2].y);
      ex_q[2]  <= EDGE_W'(nodes_i[1].x) - EDGE_W'(nodes_i[0].x);
      ey_q[2]  <= EDGE_W'(nodes_i[1].y) - EDGE_W'(nodes_i[0].y);
    end else if (busy_q) begin
      unique case (ph_q)
        4'd0: prod_q <= ex_q[ia] * ex_q[ja];
        4'd1: begin
          dot_q  <= DOT_W'(prod_q);
          prod_q <= ey_q[ia] * ey_q[ja];
        end
        4'd2: dot_q <= dot_q + DOT_W'(prod_q);
        4'd3: begin
          mag_q <= dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
          neg_q <= dot_q[DOT_W-1];
          acc_q <= '0;
        end
        4'd4: pp_q <= pp_w;
        4'd5: begin
          acc_q <= acc_q + ACC_W'(pp_q);
          pp_q  <= pp_w;
        end
        4'd6: begin
          acc_q <= acc_q + (ACC_W'(pp_q) << CHUNK_W);
          pp_q  <= pp_w;
        end
        4'd7: acc_q <= acc_q + (ACC_W'(pp_q) << (2*CHUNK_W));
        default: k_q[pair_q] <= k_w;
      endcase
    end
  end

  assign done_o = done_q;
  assign k_o    = k_q;

endmodule

FILE: sv/p1_stiffness_matrix_assembly.sv
// p1 triangle stiffness matrix assembly: load node, read-and-clear and element requests; an element
// takes 3 node reads, the divider, the entry unit and 9 read-modify-writes into the
// single-port matrix memory; one request at a time
// result register lets the next request enter while a result waits
// async active-low reset; afterwards all entries of the matrix memory are cleared,
// requests are held off meanwhile, configuration writes are always taken
module p1_stiffness_matrix_assembly
  import psma_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // node_index, node_x, node_y, node_coef, vert_a, vert_b, vert_c, element_area,
  // read_row, read_col
  input  logic [143:0] s_tdata_i,
  // opcode
  input  logic [1:0]   s_tuser_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // read_value
  output logic [47:0]  m_tdata_o,
  // status
  output logic [1:0]   m_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [8:0]   cfg_data_i
);

  state_e                    state_q, state_d;
  logic [3:0]                cnt_q, cnt_d;
  logic [CNT_W-1:0]          node_count_q;
  logic [1:0]                op_q;
  logic [IDX_W-1:0]          idx_q;
  node_t                     nin_q;
  logic [IDX_W-1:0]          vert_q [3];
  logic [COORD_W-1:0]        area_q;
  logic [IDX_W-1:0]          rrow_q, rcol_q;
  node_t [2:0]               nodes_q;
  logic signed [ENTRY_W-1:0] res_val_q;
  logic [1:0]                res_st_q;
  logic                      out_valid_q;
  logic signed [ENTRY_W-1:0] out_val_q;
  logic [1:0]                out_st_q;

  node_req_t                 node_req;
  node_t                     node_rdata;
  mat_req_t                  mat_req;
  logic signed [ENTRY_W-1:0] mat_rdata;
  logic                      mat_ready;
  logic                      div_start, div_done;
  logic [NUM_W-1:0]          div_num, f_w;
  logic [DEN_W-1:0]          div_den;
  logic [SUM_W-1:0]          coef_sum;
  logic                      k_start, k_done;
  logic signed [ENTRY_W-1:0] k_w [6];
  logic                      accept, load_out;
  logic                      load_bad, elem_bad, read_bad;
  logic [ADDR_W-1:0]         rmw_addr;
  logic signed [ENTRY_W:0]   acc_sum;
  logic signed [ENTRY_W-1:0] acc_sat;

  assign accept      = s_tvalid_i && s_tready_o;
  assign s_tready_o  = (state_q == ST_IDLE) && mat_ready;
  assign cfg_ready_o = 1'b1;

  assign load_bad = {1'b0, idx_q} >= node_count_q;
  assign elem_bad = ({1'b0, vert_q[0]} >= node_count_q) || ({1'b0, vert_q[1]} >= node_count_q)
                 || ({1'b0, vert_q[2]} >= node_count_q);
  assign read_bad = ({1'b0, rrow_q} >= node_count_q) || ({1'b0, rcol_q} >= node_count_q);

  assign coef_sum = SUM_W'(nodes_q[0].coef) + SUM_W'(nodes_q[1].coef) + SUM_W'(nodes_q[2].coef);
  assign div_num  = (NUM_W'(coef_sum) << FRAC) + NUM_W'({area_q, 2'b00})
                  + NUM_W'({area_q, 1'b0});
  assign div_den  = DEN_W'({area_q, 3'b000}) + DEN_W'({area_q, 2'b00});

  assign rmw_addr = {vert_q[ROW_OF[cnt_q]], vert_q[COL_OF[cnt_q]]};
  assign acc_sum  = {mat_rdata[ENTRY_W-1], mat_rdata}
                  + {k_w[PAIR_OF[cnt_q]][ENTRY_W-1], k_w[PAIR_OF[cnt_q]]};
  always_comb begin
    if (acc_sum[ENTRY_W] != acc_sum[ENTRY_W-1]) begin
      acc_sat = acc_sum[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX;
    end else begin
      acc_sat = acc_sum[ENTRY_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    node_req  = '0;
    mat_req   = '0;
    div_start = 1'b0;
    k_start   = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_DONE;
        unique case (op_q)
          OP_LOAD: begin
            node_req.we    = !load_bad;
            node_req.addr  = idx_q;
            node_req.wdata = nin_q;
          end
          OP_ELEM: begin
            if (!elem_bad && area_q != '0) begin
              state_d = ST_NREAD;
              cnt_d   = '0;
            end
          end
          OP_READ: begin
            if (!read_bad) begin
              mat_req.re   = 1'b1;
              mat_req.addr = {rrow_q, rcol_q};
              state_d      = ST_MCLR;
            end
          end
          default: ;
        endcase
      end
      ST_NREAD: begin
        if (cnt_q != 4'd3) begin
          node_req.re   = 1'b1;
          node_req.addr = vert_q[cnt_q[1:0]];
          cnt_d         = cnt_q + 4'd1;
        end else begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          k_start = 1'b1;
          state_d = ST_KCALC;
        end
      end
      ST_KCALC: begin
        if (k_done) begin
          cnt_d   = '0;
          state_d = ST_RMW_RD;
        end
      end
      ST_RMW_RD: begin
        mat_req.re   = 1'b1;
        mat_req.addr = rmw_addr;
        state_d      = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        mat_req.we    = 1'b1;
        mat_req.addr  = rmw_addr;
        mat_req.wdata = acc_sat;
        if (cnt_q == 4'd8) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q + 4'd1;
          state_d = ST_RMW_RD;
        end
      end
      ST_MCLR: begin
        mat_req.we   = 1'b1;
        mat_req.addr = {rrow_q, rcol_q};
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      node_count_q <= CNT_W'(NODES);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= s_tuser_i;
      idx_q      <= s_tdata_i[7:0];
      nin_q.x    <= s_tdata_i[31:8];
      nin_q.y    <= s_tdata_i[55:32];
      nin_q.coef <= s_tdata_i[79:56];
      vert_q[0]  <= s_tdata_i[87:80];
      vert_q[1]  <= s_tdata_i[95:88];
      vert_q[2]  <= s_tdata_i[103:96];
      area_q     <= s_tdata_i[127:104];
      rrow_q     <= s_tdata_i[135:128];
      rcol_q     <= s_tdata_i[143:136];
      res_val_q  <= '0;
      res_st_q   <= STAT_OK;
    end
    if (state_q == ST_DECODE) begin
      unique case (op_q)
        OP_LOAD: res_st_q <= load_bad ? STAT_INDEX : STAT_OK;
        OP_ELEM: res_st_q <= elem_bad ? STAT_INDEX : (area_q == '0) ? STAT_AREA : STAT_OK;
        OP_READ: res_st_q <= read_bad ? STAT_INDEX : STAT_OK;
        default: res_st_q <= STAT_OK;
      endcase
    end
    if (state_q == ST_NREAD && cnt_q != '0) begin
      nodes_q[cnt_q[1:0] - 2'd1] <= node_rdata;
    end
    if (state_q == ST_MCLR) begin
      res_val_q <= mat_rdata;
    end
    if (load_out) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_val_q;
  assign m_tuser_o  = out_st_q;

  assign f_w = '0;

  psma_node_mem u_node_mem (
    .clk_i   (clk_i),
    .req_i   (node_req),
    .rdata_o (node_rdata)
  );

  psma_mat_mem u_mat_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mat_req),
    .rdata_o (mat_rdata),
    .ready_o (mat_ready)
  );

  logic [NUM_W-1:0] factor;

  psma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num | f_w),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (factor)
  );

  psma_kcalc u_kcalc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (k_start),
    .f_i     (factor),
    .nodes_i (nodes_q),
    .done_o  (k_done),
    .k_o     (k_w)
  );

endmodule

FILE: sv/psma_checker.sv
// port-level checks of the stiffness matrix assembly block
// bound to p1_stiffness_matrix_assembly; depends on psma_pkg
module psma_checker
  import psma_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid_i,
  input logic         s_tready_o,
  input logic         m_tvalid_o,
  input logic         m_tready_i,
  input logic [47:0]  m_tdata_o,
  input logic [1:0]   m_tuser_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tuser_o <= STAT_AREA)
    else $error("unused status code");

  // rejected requests carry a zero value
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o != STAT_OK |-> m_tdata_o == 48'd0)
    else $error("nonzero value on rejected request");

endmodule

bind p1_stiffness_matrix_assembly psma_checker u_psma_checker (.*);

FILE: tb/sv/tb_p1_stiffness_matrix_assembly.sv
// testbench for p1_stiffness_matrix_assembly: directed and random requests checked against
// an in-bench predictor of the node tables and the saturating matrix store
// depends on psma_pkg and the p1_stiffness_matrix_assembly rtl
module tb_p1_stiffness_matrix_assembly;
  import psma_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int IDLE_CYCLES = 200;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         nidx;
    logic signed [23:0] nx;
    logic signed [23:0] ny;
    logic [23:0]        ncoef;
    logic [7:0]         va;
    logic [7:0]         vb;
    logic [7:0]         vc;
    logic [23:0]        area;
    logic [7:0]         rrow;
    logic [7:0]         rcol;
  } fem_req_t;

  typedef struct {
    logic [47:0] value;
    logic [1:0]  status;
  } fem_resp_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [143:0] s_tdata_i;
  logic [1:0]   s_tuser_i;
  logic         m_tvalid_o;
  logic         m_tready_i;
  logic [47:0]  m_tdata_o;
  logic [1:0]   m_tuser_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [8:0]   cfg_data_i;

  p1_stiffness_matrix_assembly DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state
  longint          node_x_tab [256];
  longint          node_y_tab [256];
  longint unsigned node_c_tab [256];
  bit              node_loaded [256];
  longint          stiff_mat [65536];
  int unsigned     node_limit;

  fem_resp_t   expected_resp [$];
  int          error_count;
  int          burst_left;
  int          idle_count;
  logic [7:0]  recent_verts [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_entry(input longint v);
    if (v > longint'(ENTRY_MAX)) return longint'(ENTRY_MAX);
    if (v < longint'(ENTRY_MIN)) return longint'(ENTRY_MIN);
    return v;
  endfunction

  function automatic longint scale_dot(input longint unsigned f, input longint d);
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] top;
    longint unsigned mag;
    mag  = (d < 0) ? longint'(-d) : longint'(d);
    top  = 128'd1 << 47;
    prod = 128'(f) * 128'(mag);
    q    = (prod + (128'd1 << 31)) >> 32;
    if (q > top) q = top;
    if (d < 0) return (q == top) ? longint'(ENTRY_MIN) : -longint'(q);
    return (q == top) ? longint'(ENTRY_MAX) : longint'(q);
  endfunction

  function automatic void add_entry(input logic [7:0] r, input logic [7:0] c, input longint v);
    int unsigned i;
    i = 32'({r, c});
    stiff_mat[i] = clamp_entry(stiff_mat[i] + v);
  endfunction

  function automatic fem_resp_t predict_assembly(input fem_req_t q);
    fem_resp_t       res;
    logic [7:0]      v [3];
    longint unsigned coef_sum;
    longint unsigned den;
    longint unsigned fac;
    longint          ex [3];
    longint          ey [3];
    longint          k [3][3];
    int unsigned     i;
    res.value  = '0;
    res.status = STAT_OK;
    v[0] = q.va;
    v[1] = q.vb;
    v[2] = q.vc;
    case (q.op)
      OP_LOAD: begin
        if (q.nidx >= node_limit) begin
          res.status = STAT_INDEX;
        end else begin
          node_x_tab[q.nidx]  = longint'(q.nx);
          node_y_tab[q.nidx]  = longint'(q.ny);
          node_c_tab[q.nidx]  = 64'(q.ncoef);
          node_loaded[q.nidx] = 1'b1;
        end
      end
      OP_ELEM: begin
        if (v[0] >= node_limit || v[1] >= node_limit || v[2] >= node_limit) begin
          res.status = STAT_INDEX;
        end else if (q.area == 0) begin
          res.status = STAT_AREA;
        end else begin
          coef_sum = node_c_tab[v[0]] + node_c_tab[v[1]] + node_c_tab[v[2]];
          den = 12 * longint'(q.area);
          fac = ((coef_sum << FRAC) + 6 * longint'(q.area)) / den;
          ex[0] = node_x_tab[v[2]] - node_x_tab[v[1]];
          ey[0] = node_y_tab[v[2]] - node_y_tab[v[1]];
          ex[1] = node_x_tab[v[0]] - node_x_tab[v[2]];
          ey[1] = node_y_tab[v[0]] - node_y_tab[v[2]];
          ex[2] = node_x_tab[v[1]] - node_x_tab[v[0]];
          ey[2] = node_y_tab[v[1]] - node_y_tab[v[0]];
          for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
              k[a][b] = scale_dot(fac, ex[a] * ex[b] + ey[a] * ey[b]);
          for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
              add_entry(v[a], v[b], k[a][b]);
        end
      end
      OP_READ: begin
        if (q.rrow >= node_limit || q.rcol >= node_limit) begin
          res.status = STAT_INDEX;
        end else begin
          i = 32'({q.rrow, q.rcol});
          res.value = stiff_mat[i][47:0];
          stiff_mat[i] = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_request(input fem_req_t q);
    if (burst_left == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= q.op;
    s_tdata_i  <= {q.rcol, q.rrow, q.area, q.vc, q.vb, q.va, q.ncoef, q.ny, q.nx, q.nidx};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    expected_resp.push_back(predict_assembly(q));
    if (q.op == OP_ELEM) begin
      recent_verts.push_back(q.va);
      recent_verts.push_back(q.vb);
      recent_verts.push_back(q.vc);
      while (recent_verts.size() > 24) void'(recent_verts.pop_front());
    end
  endtask

  task automatic drain;
    s_tvalid_i <= 1'b0;
    while (expected_resp.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [8:0] cnt);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    node_limit = (cnt < 9'd256) ? 32'(cnt) : 32'd256;
  endtask

  function automatic fem_req_t blank_req(input logic [1:0] op);
    fem_req_t q;
    q = '{op: op, nidx: 0, nx: 0, ny: 0, ncoef: 0, va: 0, vb: 0, vc: 0,
          area: 0, rrow: 0, rcol: 0};
    return q;
  endfunction

  function automatic fem_req_t load_req(input logic [7:0] n, input logic [23:0] x,
                                        input logic [23:0] y, input logic [23:0] c);
    fem_req_t q;
    q = blank_req(OP_LOAD);
    q.nidx = n;
    q.nx = x;
    q.ny = y;
    q.ncoef = c;
    return q;
  endfunction

  function automatic fem_req_t elem_req(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [23:0] ar);
    fem_req_t q;
    q = blank_req(OP_ELEM);
    q.va = a;
    q.vb = b;
    q.vc = c;
    q.area = ar;
    return q;
  endfunction

  function automatic fem_req_t read_req(input logic [7:0] r, input logic [7:0] c);
    fem_req_t q;
    q = blank_req(OP_READ);
    q.rrow = r;
    q.rcol = c;
    return q;
  endfunction

  task automatic test_directed;
    write_node_count(9'd256);
    send_request(load_req(8'd0, 24'h000000, 24'h000000, 24'h010000));
    send_request(load_req(8'd1, 24'h010000, 24'h000000, 24'h010000));
    send_request(load_req(8'd2, 24'h000000, 24'h010000, 24'h010000));
    send_request(load_req(8'd254, 24'h800000, 24'h7fffff, 24'hffffff));
    send_request(load_req(8'd255, 24'h7fffff, 24'h800000, 24'hffffff));
    send_request(elem_req(8'd0, 8'd1, 8'd2, 24'h008000));
    send_request(read_req(8'd0, 8'd0));
    send_request(read_req(8'd1, 8'd2));
    send_request(read_req(8'd1, 8'd2));
    // huge edges and tiny area saturate the entries
    send_request(elem_req(8'd254, 8'd255, 8'd0, 24'h000001));
    send_request(elem_req(8'd254, 8'd255, 8'd0, 24'h000001));
    send_request(read_req(8'd254, 8'd254));
    send_request(read_req(8'd254, 8'd255));
    send_request(elem_req(8'd1, 8'd2, 8'd0, 24'hffffff));
    send_request(elem_req(8'd0, 8'd1, 8'd2, 24'h000000));
    // repeated vertices
    send_request(elem_req(8'd1, 8'd1, 8'd2, 24'h010000));
    send_request(read_req(8'd1, 8'd1));
    send_request(read_req(8'd255, 8'd255));
    send_request(blank_req(OP_NONE));
    send_request(read_req(8'd255, 8'd0));
  endtask

  task automatic test_bad_index;
    write_node_count(9'd3);
    send_request(load_req(8'd200, 24'h123456, 24'h654321, 24'h111111));
    send_request(load_req(8'd3, 24'h0, 24'h0, 24'h0));
    send_request(elem_req(8'd0, 8'd5, 8'd1, 24'h000000));
    send_request(elem_req(8'd0, 8'd1, 8'd2, 24'h000000));
    send_request(read_req(8'd7, 8'd0));
    send_request(read_req(8'd0, 8'd3));
    write_node_count(9'd1);
    send_request(elem_req(8'd0, 8'd0, 8'd0, 24'h010000));
    send_request(elem_req(8'd0, 8'd0, 8'd1, 24'h010000));
    send_request(read_req(8'd0, 8'd0));
  endtask

  function automatic logic [7:0] pick_vertex();
    int unsigned span;
    logic [7:0] n;
    if (node_limit < 256 && $urandom_range(0, 19) == 0) begin
      return 8'($urandom_range(node_limit, 255));
    end
    span = ($urandom_range(0, 3) != 0 && node_limit > 16) ? 16 : node_limit;
    repeat (20) begin
      n = 8'($urandom_range(0, span - 1));
      if (node_loaded[n]) return n;
    end
    return 8'd0;
  endfunction

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(0, 9) < 7) return 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    return 24'($urandom_range(0, 24'hffffff));
  endfunction

  function automatic fem_req_t random_req();
    fem_req_t q;
    int unsigned pick;
    logic [23:0] ar;
    q = blank_req(OP_NONE);
    q.nidx = 8'($urandom);
    q.nx = 24'($urandom);
    q.ny = 24'($urandom);
    q.ncoef = 24'($urandom);
    q.va = 8'($urandom);
    q.vb = 8'($urandom);
    q.vc = 8'($urandom);
    q.area = 24'($urandom);
    q.rrow = 8'($urandom);
    q.rcol = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      q.op = OP_LOAD;
      if ($urandom_range(0, 2) != 0) q.nidx = 8'($urandom_range(0, 15));
      q.nx = rand_coord();
      q.ny = rand_coord();
      if ($urandom_range(0, 3) != 0) q.ncoef = 24'($urandom_range(0, 24'h0fffff));
    end else if (pick < 70) begin
      q.op = OP_ELEM;
      q.va = pick_vertex();
      q.vb = pick_vertex();
      q.vc = pick_vertex();
      case ($urandom_range(0, 9))
        0: ar = 24'd0;
        1: ar = 24'($urandom_range(1, 255));
        2: ar = 24'($urandom_range(24'h100000, 24'hffffff));
        default: ar = 24'($urandom_range(24'h001000, 24'h0fffff));
      endcase
      q.area = ar;
    end else if (pick < 95) begin
      q.op = OP_READ;
      if (recent_verts.size() != 0 && $urandom_range(0, 9) < 7) begin
        q.rrow = recent_verts[$urandom_range(0, recent_verts.size() - 1)];
        q.rcol = recent_verts[$urandom_range(0, recent_verts.size() - 1)];
      end
    end
    return q;
  endfunction

  task automatic test_random(input logic [8:0] cnt, input int count);
    write_node_count(cnt);
    repeat (count) send_request(random_req());
  endtask

  // receiver stall pattern
  int unsigned stall_mode;
  int unsigned stall_left;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready_i <= 1'b1;
      1: m_tready_i <= 1'($urandom_range(0, 1));
      2: m_tready_i <= ($urandom_range(0, 7) == 0);
      default: m_tready_i <= (stall_left[3:0] < 4'd10);
    endcase
  end

  always @(posedge clk_i) begin
    fem_resp_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_resp.size() == 0) begin
        report_mismatch("unexpected result", m_tdata_o, 48'd0);
      end else begin
        want = expected_resp.pop_front();
        if (m_tdata_o !== want.value) report_mismatch("read_value", m_tdata_o, want.value);
        if (m_tuser_o !== want.status) report_mismatch("status", 48'(m_tuser_o), 48'(want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("p1_stiffness_matrix_assembly test failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    s_tuser_i   = OP_LOAD;
    m_tready_i  = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    stall_mode  = 0;
    stall_left  = 0;
    idle_count  = 0;
    error_count = 0;
    burst_left  = 0;
    node_limit  = 256;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bad_index();
    test_random(9'd256, 500);
    test_random(9'd511, 400);
    test_random(9'd200, 400);
    test_random(9'd3, 200);
    test_random(9'd37, 500);
    drain();
    if (error_count == 0) begin
      $display("p1_stiffness_matrix_assembly test passed");
    end else begin
      $display("p1_stiffness_matrix_assembly test failed");
    end
    $finish;
  end

endmodule
